/* hdl/khmap_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khmap_pkg
// Shared types and constants for the key to index hash map: slot layout,
// result codes and the command and status bundles between control and data.
// ----------------------------------------------------------------------------
package khmap_pkg;

    localparam int SLOTS_DEF       = 128;
    localparam int MAX_ENTRIES_DEF = 96;

    localparam int KEY_W    = 32;
    localparam int IDX_W    = 7;
    localparam int STATUS_W = 2;

    localparam logic [KEY_W-1:0] HASH_MUL = 32'h045d_9f3b;
    localparam int               FOLD_SH  = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] index;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic clear;       // write one invalid slot and advance the sweep
        logic load;        // capture the incoming transaction
        logic hash_first;  // first multiply round on the key
        logic hash_second; // second multiply round on the hash
        logic home;        // load the home slot, start probing
        logic step;        // move to the next slot
        logic finish;      // commit the result and any insert
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic hit;
        logic empty;
        logic exhausted;
        logic out_busy;
    } sts_t;

    function automatic logic [KEY_W-1:0] xor_fold(input logic [KEY_W-1:0] x);
        return x ^ (x >> FOLD_SH);
    endfunction

endpackage
`default_nettype wire

/* hdl/key_to_index_hash_map_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// an accepted transaction runs two hash rounds and the home slot load, then
// the probe checks one slot per cycle until a hit, an empty slot or a full wrap
// one transaction at a time: the next is taken only after the last result is
// committed, and a finished result waiting on out_stall holds it off
// reset: after rst_n releases, a clearing sweep over all SLOTS slots (128 by
// default) marks every slot invalid; in_stall stays high during the sweep
// ----------------------------------------------------------------------------
// key_to_index_hash_map_top
// Open-addressed linear probing table that gives dense indices to 32-bit keys
// in order of first insertion; each transaction is a lookup or an insert.
// ----------------------------------------------------------------------------
module key_to_index_hash_map_top
    import khmap_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    mode,
    input  logic signed [KEY_W-1:0] key,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STATUS_W-1:0]     status,
    output logic [IDX_W-1:0]        index
);

    cmd_t cmd;
    sts_t sts;

    khmap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    khmap_dp #(
        .SLOTS       (SLOTS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .index     (index),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire

/* hdl/khmap_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khmap_ctrl
// Sequencer for the hash map: clearing sweep after reset, two hash rounds,
// then one slot check per cycle until hit, empty slot or full wrap.
// ----------------------------------------------------------------------------
module khmap_ctrl
    import khmap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_HASH_A = 6'b000100,
        S_HASH_B = 6'b001000,
        S_HOME   = 6'b010000,
        S_CHECK  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   probe_done;

    assign probe_done = sts.hit || sts.empty || sts.exhausted;
    assign in_stall   = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH_A;
                end
            end
            S_HASH_A:
            begin
                cmd.hash_first = 1'b1;
                state_next     = S_HASH_B;
            end
            S_HASH_B:
            begin
                cmd.hash_second = 1'b1;
                state_next      = S_HOME;
            end
            S_HOME:
            begin
                cmd.home   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (probe_done)
                begin
                    // hold the answer until the output register is free
                    if (!sts.out_busy)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_hit_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && sts.hit && !sts.out_busy) |=> state_reg == S_IDLE)
        else $error("lookup hit did not complete");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (in_stall && !cmd.load))
        else $error("transaction taken during clearing sweep");
`endif

endmodule
`default_nettype wire

/* hdl/khmap_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khmap_dp
// Datapath of the hash map: input capture, shared hash multiplier, slot
// memory with registered read, probe position, entry counter, result register.
// ----------------------------------------------------------------------------
module khmap_dp
    import khmap_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       mode,
    input  logic signed [KEY_W-1:0]    key,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [IDX_W-1:0]           index,
    input  cmd_t                       cmd,
    output sts_t                       sts
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    entry_t              mem [SLOTS];
    entry_t              rd_reg;

    logic                mode_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    h_reg;
    logic [KEY_W-1:0]    mul_op;
    logic [KEY_W-1:0]    mul_prod;
    logic [SLOT_W-1:0]   pos_reg;
    logic [SLOT_W-1:0]   pos_next;
    logic [SLOT_W-1:0]   probes_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                full;

    status_t             res_status;
    logic [IDX_W-1:0]    res_index;
    logic                ins_we;
    logic                mem_we;
    entry_t              mem_wdata;

    logic                out_valid_reg;
    status_t             status_reg;
    logic [IDX_W-1:0]    index_reg;

    // one multiplier, used by both hash rounds
    assign mul_op   = xor_fold(cmd.hash_first ? key_reg : h_reg);
    assign mul_prod = mul_op * HASH_MUL;

    assign full = (count_reg >= CNT_W'(MAX_ENTRIES));

    assign sts.clear_last = &pos_reg;
    assign sts.hit        = rd_reg.valid && (rd_reg.key == key_reg);
    assign sts.empty      = !rd_reg.valid;
    assign sts.exhausted  = &probes_reg;
    assign sts.out_busy   = out_valid_reg && out_stall;

    always_comb
    begin
        res_index = '0;
        if (sts.hit)
        begin
            res_status = ST_FOUND;
            res_index  = rd_reg.index;
        end
        else if (!mode_reg)
        begin
            res_status = ST_NOT_FOUND;
        end
        else if (full || !sts.empty)
        begin
            res_status = ST_FULL;
        end
        else
        begin
            res_status = ST_INSERTED;
            res_index  = IDX_W'(count_reg);
        end
    end

    assign ins_we = cmd.finish && (res_status == ST_INSERTED);
    assign mem_we = cmd.clear || ins_we;

    always_comb
    begin
        mem_wdata = '0;
        if (!cmd.clear)
        begin
            mem_wdata.valid = 1'b1;
            mem_wdata.key   = key_reg;
            mem_wdata.index = res_index;
        end
    end

    // memory read address follows the next position so rd_reg matches pos_reg
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.home)
        begin
            pos_next = SLOT_W'(xor_fold(h_reg));
        end
        else if (cmd.step || cmd.clear)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos_reg] <= mem_wdata;
        end
        rd_reg <= mem[pos_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            key_reg  <= $unsigned(key);
        end
        if (cmd.hash_first || cmd.hash_second)
        begin
            h_reg <= mul_prod;
        end
        if (cmd.finish)
        begin
            status_reg <= res_status;
            index_reg  <= res_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            probes_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (cmd.home)
            begin
                probes_reg <= '0;
            end
            else if (cmd.step)
            begin
                probes_reg <= probes_reg + 1'b1;
            end
            if (ins_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign index     = index_reg;

`ifndef NO_ASSERTIONS
    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        ins_we |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not advance the entry count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ins_we |-> (count_reg < CNT_W'(MAX_ENTRIES)))
        else $error("insert past the entry limit");

    a_finish_decided: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> ((sts.hit || sts.empty || sts.exhausted) && !sts.out_busy))
        else $error("result committed before probe ended or output free");
`endif

endmodule
`default_nettype wire
